// ===== rtl/four_lane_fnv1a_digest_macros.svh =====
// assertion macros for the four lane fnv-1a digest checker
// no dependencies; included by the checker file
`ifndef FOUR_LANE_FNV1A_DIGEST_MACROS_SVH
`define FOUR_LANE_FNV1A_DIGEST_MACROS_SVH

// clocked assertion, quiet while reset is asserted
`define FLD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that also holds during reset
`define FLD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/fld_pkg.sv =====
// shared types, constants and the lane update function of the digest
// no dependencies
`timescale 1ns / 1ps

package fld_pkg;

  localparam int NumLanes = 4;
  localparam int LaneW    = $clog2(NumLanes);
  localparam int WordW    = 64;

  typedef logic [WordW-1:0] word_t;
  typedef logic [LaneW-1:0] lane_idx_t;

  // 64-bit fnv prime is 2^40 + 0x1b3
  localparam int    PrimeShift   = 40;
  localparam word_t PrimeLowPart = 64'h0000_0000_0000_01b3;

  localparam word_t FnvBasis = 64'hcbf2_9ce4_8422_2325;

  localparam word_t RotBases [NumLanes] = '{
    64'hcbf2_9ce4_8422_2325,
    64'h8422_2325_cbf2_9ce4,
    64'hf29c_e484_2223_25cb,
    64'h2223_25cb_f29c_e484
  };

  // starting value of one lane for the given seed mode
  function automatic word_t lane_seed(input logic mode, input lane_idx_t idx);
    lane_seed = mode ? FnvBasis : RotBases[idx];
  endfunction

  // one fnv-1a step: xor the byte in, multiply by the prime mod 2^64
  function automatic word_t fnv_step(input word_t acc, input logic [7:0] data);
    word_t x;
    x = acc ^ {{(WordW-8){1'b0}}, data};
    fnv_step = (x << PrimeShift) + (x * PrimeLowPart);
  endfunction

endpackage

// ===== rtl/fld_in_if.sv =====
// input channel of the digest: one message byte per transfer
// depends on nothing
`timescale 1ns / 1ps

interface fld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output has_byte,
                  output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input has_byte,
                  input end_of_message, output ready);
endinterface

// ===== rtl/fld_out_if.sv =====
// output channel of the digest: one lane word per transfer
// depends on nothing
`timescale 1ns / 1ps

interface fld_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] lane_word;
  logic [1:0]  lane_number;
  logic        last_word;

  modport source (output valid, output lane_word, output lane_number,
                  output last_word, input ready);
  modport sink   (input valid, input lane_word, input lane_number,
                  input last_word, output ready);
endinterface

// ===== rtl/four_lane_fnv1a_digest.sv =====
// top level of the four lane interleaved fnv-1a digest
// depends on fld_pkg, fld_in_if and fld_out_if
`timescale 1ns / 1ps

// Four-lane interleaved FNV-1a digest. Message bytes arrive one per transfer
// on in_i; byte i of a message is folded into 64-bit lane (i mod 4) with an
// xor and a multiply by the 64-bit FNV prime, all in the cycle the byte is
// taken, so the block takes one input transfer per clock as long as it is
// not stalled. A transfer with end_of_message set (with or without a byte)
// closes the message: the four lane words, lane 0 first, leave on out_o on
// four transfers, one word per cycle while out_o.ready is high, starting the
// cycle after the close when the output is idle, and the lanes reload for the
// next message. One finished digest may wait in a snapshot buffer while the
// previous one drains; once a second message closes before the output has
// taken all four words of the first, in_i.ready drops for every item and rises
// again the cycle after the waiting digest moves to the output. Short messages
// are therefore limited by the single-word output port, four words per digest.
// seed_mode (cfg_wdata_i on a cycle with cfg_we_i high) picks rotated offset
// bases (0) or the standard basis in all lanes (1); every write reloads the
// lanes and drops any message in progress, and is meant for idle periods.
module four_lane_fnv1a_digest import fld_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  fld_in_if.sink    in_i,
  fld_out_if.source out_o
);

  // configuration and accumulator state
  logic      seed_mode_q;
  word_t     lane_q [NumLanes];
  lane_idx_t pos_q;

  // output word buffer (shifts toward entry 0) and snapshot buffer
  word_t     out_word_q  [NumLanes];
  logic      out_vld_q;
  lane_idx_t out_cnt_q;
  word_t     pend_word_q [NumLanes];
  logic      pend_vld_q;

  logic  in_fire;
  logic  close;
  logic  out_fire;
  logic  out_done;
  logic  out_free;
  word_t upd_word;
  word_t fin_word [NumLanes];

  // a new item is refused only while a digest sits in the snapshot buffer
  assign in_i.ready = !pend_vld_q;
  assign in_fire    = in_i.valid && in_i.ready;
  assign close      = in_fire && in_i.end_of_message;

  assign out_fire = out_o.valid && out_o.ready;
  assign out_done = out_fire && (out_cnt_q == lane_idx_t'(NumLanes - 1));
  // output buffer can load a new digest this cycle
  assign out_free = !out_vld_q || out_done;

  // only the lane at the byte position changes
  assign upd_word = fnv_step(lane_q[pos_q], in_i.data_byte);

  always_comb begin
    for (int k = 0; k < NumLanes; k++) begin
      fin_word[k] = (in_i.has_byte && (pos_q == lane_idx_t'(k))) ? upd_word : lane_q[k];
    end
  end

  // accumulators, byte position and mode
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_mode_q <= 1'b0;
      pos_q       <= '0;
      for (int k = 0; k < NumLanes; k++) begin
        lane_q[k] <= RotBases[k];
      end
    end else if (cfg_we_i) begin
      // mode write reloads everything
      seed_mode_q <= cfg_wdata_i;
      pos_q       <= '0;
      for (int k = 0; k < NumLanes; k++) begin
        lane_q[k] <= lane_seed(cfg_wdata_i, lane_idx_t'(k));
      end
    end else if (close) begin
      pos_q <= '0;
      for (int k = 0; k < NumLanes; k++) begin
        lane_q[k] <= lane_seed(seed_mode_q, lane_idx_t'(k));
      end
    end else if (in_fire) begin
      if (in_i.has_byte) begin
        pos_q <= pos_q + lane_idx_t'(1);
      end
      for (int k = 0; k < NumLanes; k++) begin
        lane_q[k] <= fin_word[k];
      end
    end
  end

  // output and snapshot control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      out_cnt_q  <= '0;
      pend_vld_q <= 1'b0;
    end else begin
      if (out_free) begin
        if (pend_vld_q) begin
          // waiting digest moves to the output
          out_vld_q  <= 1'b1;
          out_cnt_q  <= '0;
          pend_vld_q <= 1'b0;
        end else if (close) begin
          // closing digest goes straight to the output
          out_vld_q <= 1'b1;
          out_cnt_q <= '0;
        end else begin
          out_vld_q <= 1'b0;
        end
      end else begin
        if (out_fire) begin
          out_cnt_q <= out_cnt_q + lane_idx_t'(1);
        end
        if (close) begin
          pend_vld_q <= 1'b1;
        end
      end
    end
  end

  // digest payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      for (int k = 0; k < NumLanes; k++) begin
        out_word_q[k] <= pend_vld_q ? pend_word_q[k] : fin_word[k];
      end
    end else if (out_fire) begin
      for (int k = 0; k < NumLanes - 1; k++) begin
        out_word_q[k] <= out_word_q[k+1];
      end
    end
    if (close) begin
      for (int k = 0; k < NumLanes; k++) begin
        pend_word_q[k] <= fin_word[k];
      end
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.lane_word   = out_word_q[0];
  assign out_o.lane_number = out_cnt_q;
  assign out_o.last_word   = (out_cnt_q == lane_idx_t'(NumLanes - 1));

endmodule

// ===== rtl/fld_chk.sv =====
// port-level checker for the digest and its bind to the top level
// depends on four_lane_fnv1a_digest_macros.svh
`timescale 1ns / 1ps
`include "four_lane_fnv1a_digest_macros.svh"

module fld_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_eom_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [63:0] out_word_i,
  input logic [1:0]  out_lane_i,
  input logic        out_last_i
);

  // a stalled word holds
  `FLD_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_word_i) && $stable(out_lane_i)), "stalled output word changed")

  // words of one digest follow each other without a gap, lane by lane
  `FLD_ASSERT(a_lane_seq, clk_i, rst_ni, (out_valid_i && out_ready_i && !out_last_i) |=> (out_valid_i && (out_lane_i == $past(out_lane_i) + 2'd1)), "digest words out of order")

  // a new digest always starts at lane 0
  `FLD_ASSERT(a_new_digest, clk_i, rst_ni, (out_valid_i && out_ready_i && out_last_i) |=> (!out_valid_i || (out_lane_i == 2'd0)), "digest did not start at lane 0")

  // closing a message with an idle output shows lane 0 next cycle
  `FLD_ASSERT(a_close_out, clk_i, rst_ni, (in_valid_i && in_ready_i && in_eom_i && !out_valid_i) |=> (out_valid_i && (out_lane_i == 2'd0)), "closed message gave no digest")

  // the last flag marks lane 3 exactly
  `FLD_ASSERT_ALWAYS(a_last_flag, clk_i, (!out_valid_i || (out_last_i == (out_lane_i == 2'd3))), "last flag not on lane 3")

endmodule

bind four_lane_fnv1a_digest fld_chk u_fld_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_eom_i    (in_i.end_of_message),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_word_i  (out_o.lane_word),
  .out_lane_i  (out_o.lane_number),
  .out_last_i  (out_o.last_word)
);

// ===== tb/testbench.sv =====
// self-checking testbench for the four lane interleaved fnv-1a digest
// depends on fld_pkg, fld_in_if, fld_out_if and four_lane_fnv1a_digest
// directed table first, then three randomized phases with varying back-pressure
`timescale 1ns / 1ps

module testbench;
  import fld_pkg::*;

  // independent copies of the digest constants
  localparam word_t FNV_PRIME = 64'h0000_0100_0000_01b3;
  localparam word_t STD_BASIS = 64'hcbf2_9ce4_8422_2325;
  localparam word_t ROT_BASIS [4] = '{
    64'hcbf2_9ce4_8422_2325, 64'h8422_2325_cbf2_9ce4,
    64'hf29c_e484_2223_25cb, 64'h2223_25cb_f29c_e484
  };
  // fnv-1a 64 of the single byte "a" from the standard basis
  localparam word_t FNV_OF_A = 64'haf63_dc4c_8601_ec8c;

  // typed-in digests, lane 3 in the top word
  localparam logic [3:0][63:0] NO_DIGEST  = '0;
  localparam logic [3:0][63:0] ROT_EMPTY  = {64'h2223_25cb_f29c_e484,
    64'hf29c_e484_2223_25cb, 64'h8422_2325_cbf2_9ce4, 64'hcbf2_9ce4_8422_2325};
  localparam logic [3:0][63:0] ROT_A      = {64'h2223_25cb_f29c_e484,
    64'hf29c_e484_2223_25cb, 64'h8422_2325_cbf2_9ce4, FNV_OF_A};
  localparam logic [3:0][63:0] STD_EMPTY  = {4{STD_BASIS}};
  localparam logic [3:0][63:0] STD_A      = {STD_BASIS, STD_BASIS, STD_BASIS, FNV_OF_A};

  typedef enum logic {ACT_ITEM, ACT_SET_MODE} row_act_e;

  // one row of the directed table; for a mode write the mode is data_byte[0]
  typedef struct packed {
    row_act_e         act;
    logic [7:0]       data_byte;
    logic             has_byte;
    logic             end_of_message;
    logic             pinned;
    logic [3:0][63:0] digest;
  } dir_row_t;

  localparam int DIR_ROWS = 27;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // empty message right after reset gives the rotated bases
    '{ACT_ITEM,     8'h00, 1'b0, 1'b1, 1'b1, ROT_EMPTY},
    // idle transfer, its byte is ignored
    '{ACT_ITEM,     8'h5a, 1'b0, 1'b0, 1'b0, NO_DIGEST},
    // one byte that also ends the message
    '{ACT_ITEM,     8'h61, 1'b1, 1'b1, 1'b1, ROT_A},
    // five bytes, the fifth wraps back to lane 0
    '{ACT_ITEM,     8'h00, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{ACT_ITEM,     8'hff, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{ACT_ITEM,     8'h80, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{ACT_ITEM,     8'h01, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{ACT_ITEM,     8'h7f, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{ACT_ITEM,     8'haa, 1'b0, 1'b0, 1'b0, NO_DIGEST},
    // close without a byte
    '{ACT_ITEM,     8'h00, 1'b0, 1'b1, 1'b0, NO_DIGEST},
    '{ACT_SET_MODE, 8'h01, 1'b0, 1'b0, 1'b0, NO_DIGEST},
    '{ACT_ITEM,     8'hff, 1'b0, 1'b1, 1'b1, STD_EMPTY},
    '{ACT_ITEM,     8'h61, 1'b1, 1'b1, 1'b1, STD_A},
    // message in progress dropped by rewriting the same mode
    '{ACT_ITEM,     8'hff, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{ACT_ITEM,     8'h00, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{ACT_ITEM,     8'h55, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{ACT_SET_MODE, 8'h01, 1'b0, 1'b0, 1'b0, NO_DIGEST},
    '{ACT_ITEM,     8'h00, 1'b0, 1'b1, 1'b1, STD_EMPTY},
    // message dropped by switching back to mode 0
    '{ACT_ITEM,     8'h12, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{ACT_ITEM,     8'h34, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{ACT_SET_MODE, 8'h00, 1'b0, 1'b0, 1'b0, NO_DIGEST},
    '{ACT_ITEM,     8'h00, 1'b0, 1'b1, 1'b1, ROT_EMPTY},
    // five bytes ending on a byte, lane 0 takes two
    '{ACT_ITEM,     8'h01, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{ACT_ITEM,     8'h02, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{ACT_ITEM,     8'h04, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{ACT_ITEM,     8'h08, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{ACT_ITEM,     8'h10, 1'b1, 1'b1, 1'b0, NO_DIGEST}
  };

  localparam int SETTLE_CYCLES = 8;     // lanes update in the cycle a byte is taken
  localparam int DRAIN_LIMIT   = 20000;
  localparam int PHASE_ITEMS   = 135;

  typedef struct {
    word_t     word;
    lane_idx_t lane;
    logic      last;
  } lane_word_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  fld_in_if  digest_in ();
  fld_out_if digest_out ();

  four_lane_fnv1a_digest DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (digest_in),
    .out_o       (digest_out)
  );

  // digest model state
  word_t     lane_acc [4];
  lane_idx_t next_lane;
  logic      seed_mode;

  lane_word_t expected_words [$];

  int mismatch_count;
  int words_checked;
  int bytes_sent;
  int messages_closed;
  int mode_writes;
  int input_stall_cycles;
  int items_sent;

  // idling rates in percent and a one-shot request for a long receiver hold-off
  int send_idle_pct;
  int recv_idle_pct;
  int hold_request;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // digest model
  // ---------------------------------------------------------------------------

  function automatic word_t fnv1a_fold(input word_t acc, input logic [7:0] b);
    return (acc ^ {56'd0, b}) * FNV_PRIME;
  endfunction

  function automatic void reload_lanes();
    for (int k = 0; k < 4; k++) begin
      lane_acc[k] = seed_mode ? STD_BASIS : ROT_BASIS[k];
    end
    next_lane = '0;
  endfunction

  // advance the model by one accepted transfer and queue the digest it closes;
  // a pinned row queues its typed-in digest in place of the computed one
  function automatic void predict_transfer(input logic [7:0] b, input logic has_byte,
                                           input logic eom, input logic pinned,
                                           input logic [3:0][63:0] digest);
    lane_word_t w;
    if (has_byte) begin
      lane_acc[next_lane] = fnv1a_fold(lane_acc[next_lane], b);
      next_lane = next_lane + lane_idx_t'(1);     // wraps modulo 4
      bytes_sent++;
    end
    if (eom) begin
      for (int k = 0; k < 4; k++) begin
        w.word = pinned ? digest[k] : lane_acc[k];
        w.lane = lane_idx_t'(k);
        w.last = (k == 3);
        expected_words.push_back(w);
      end
      messages_closed++;
      reload_lanes();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 20) $display("tb: mismatch at %0t ns: %s", $time, msg);
  endtask

  // compare each lane word transfer with the oldest expected word
  always @(posedge clk_i) begin : lane_word_check
    lane_word_t w;
    if (rst_ni && digest_out.valid && digest_out.ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("lane word %h on lane %0d with none expected",
                                  digest_out.lane_word, digest_out.lane_number));
      end else begin
        w = expected_words.pop_front();
        words_checked++;
        if (digest_out.lane_word !== w.word)
          report_mismatch($sformatf("lane %0d word %h, expected %h",
                                    w.lane, digest_out.lane_word, w.word));
        if (digest_out.lane_number !== w.lane)
          report_mismatch($sformatf("lane number %0d, expected %0d",
                                    digest_out.lane_number, w.lane));
        if (digest_out.last_word !== w.last)
          report_mismatch($sformatf("last word flag %b on lane %0d, expected %b",
                                    digest_out.last_word, w.lane, w.last));
      end
    end
  end

  // count cycles in which the block held off an offered transfer
  always @(posedge clk_i) begin
    if (rst_ni && digest_in.valid && !digest_in.ready) input_stall_cycles++;
  end

  // ---------------------------------------------------------------------------
  // receiver: random ready, or a long hold-off when one is requested
  // ---------------------------------------------------------------------------

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    digest_out.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        digest_out.ready <= 1'b0;
        hold_left--;
      end else begin
        digest_out.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------------------

  // offer one transfer, wait for it to be taken, then maybe leave a gap;
  // valid stays high when no gap follows so back-to-back transfers never
  // lower and raise it in the same step
  task automatic send_item(input logic [7:0] b, input logic has_byte, input logic eom,
                           input logic pinned, input logic [3:0][63:0] digest);
    digest_in.valid          <= 1'b1;
    digest_in.data_byte      <= b;
    digest_in.has_byte       <= has_byte;
    digest_in.end_of_message <= eom;
    @(posedge clk_i);
    while (!digest_in.ready) @(posedge clk_i);
    predict_transfer(b, has_byte, eom, pinned, digest);
    if (has_byte || eom) items_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      digest_in.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // write seed_mode once the block has gone quiet
  task automatic write_seed_mode(input logic mode);
    digest_in.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    seed_mode = mode;
    reload_lanes();
    mode_writes++;
  endtask

  // one well-formed message with random content, now and then with idle
  // transfers mixed in; mostly short, sometimes long enough to wrap many times
  task automatic send_random_message();
    int  len;
    bit  close_on_byte;
    len = ($urandom_range(9) == 0) ? $urandom_range(40, 16) : $urandom_range(7);
    close_on_byte = (len > 0) && $urandom_range(1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(7) == 0)
        send_item(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0, NO_DIGEST);
      send_item(8'($urandom_range(255)), 1'b1, close_on_byte && (i == len - 1), 1'b0,
                NO_DIGEST);
    end
    if (!close_on_byte) send_item(8'($urandom_range(255)), 1'b0, 1'b1, 1'b0, NO_DIGEST);
  endtask

  // a broken message: a few bytes that a mode write then drops
  task automatic send_unclosed_message();
    int len;
    len = $urandom_range(5, 1);
    for (int i = 0; i < len; i++)
      send_item(8'($urandom_range(255)), 1'b1, 1'b0, 1'b0, NO_DIGEST);
  endtask

  task automatic run_random_phase(input int target);
    int stop_at;
    stop_at = items_sent + target;
    while (items_sent < stop_at) send_random_message();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin : main_sequence
    int drain;
    rst_ni                   = 1'b0;
    cfg_we_i                 = 1'b0;
    cfg_wdata_i              = 1'b0;
    digest_in.valid          = 1'b0;
    digest_in.data_byte      = 8'h00;
    digest_in.has_byte       = 1'b0;
    digest_in.end_of_message = 1'b0;
    mismatch_count     = 0;
    words_checked      = 0;
    bytes_sent         = 0;
    messages_closed    = 0;
    mode_writes        = 0;
    input_stall_cycles = 0;
    items_sent         = 0;
    hold_request       = 0;
    send_idle_pct      = 9;
    recv_idle_pct      = 57;
    seed_mode          = 1'b0;
    reload_lanes();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, sender mostly busy and receiver often stalling
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIR_TABLE[r].act == ACT_SET_MODE) begin
        write_seed_mode(DIR_TABLE[r].data_byte[0]);
      end else begin
        send_item(DIR_TABLE[r].data_byte, DIR_TABLE[r].has_byte,
                  DIR_TABLE[r].end_of_message, DIR_TABLE[r].pinned,
                  DIR_TABLE[r].digest);
      end
    end

    // phase 1: standard basis, receiver often stalls
    send_unclosed_message();
    write_seed_mode(1'b1);
    run_random_phase(PHASE_ITEMS);

    // phase 2: rotated bases, sender often idles
    send_unclosed_message();
    send_idle_pct = 57;
    recv_idle_pct = 9;
    write_seed_mode(1'b0);
    run_random_phase(PHASE_ITEMS);

    // phase 3: no idling; a long receiver hold-off first while empty
    // messages pile up so the snapshot buffer fills and in_i stalls
    send_unclosed_message();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_seed_mode(1'($urandom_range(1)));
    hold_request = 150;
    repeat (6) send_item(8'($urandom_range(255)), 1'b0, 1'b1, 1'b0, NO_DIGEST);
    run_random_phase(PHASE_ITEMS);

    // drain whatever is still owed, then a few quiet cycles
    digest_in.valid <= 1'b0;
    drain = 0;
    while (expected_words.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain++;
    end
    if (expected_words.size() != 0)
      report_mismatch($sformatf("%0d lane words never arrived", expected_words.size()));
    repeat (SETTLE_CYCLES * 4) @(posedge clk_i);

    $display("tb: %0d bytes in %0d digests, %0d lane words compared, %0d mode writes",
             bytes_sent, messages_closed, words_checked, mode_writes);
    $display("tb: input held off for %0d cycles, %0d mismatches",
             input_stall_cycles, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
